### rtl/kpec_pkg.sv
package kpec_pkg;

  localparam int unsigned LINE_W  = 8;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned LIMIT_W = 7;
  localparam int unsigned INDEX_W = 3;

  localparam logic [LINE_W-1:0]  LEVELS_RESET = 8'hff;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 7'd10;

  typedef enum logic [1:0] {
    ACT_SAMPLE       = 2'd0,
    ACT_TAKE_PRESS   = 2'd1,
    ACT_TAKE_RELEASE = 2'd2,
    ACT_CLEAR        = 2'd3
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [LINE_W-1:0]   key_levels;
    logic [INDEX_W-1:0]  key_index;
  } in_item_t;

  typedef struct packed {
    logic                granted;
    logic [LINE_W-1:0]   levels_now;
    logic [COUNT_W-1:0]  pending_count;
  } out_item_t;

  typedef struct packed {
    action_t             op;
    logic                fall;
    logic                up;
  } alu_ctl_t;

endpackage

### rtl/kpec_count_alu.sv
module kpec_count_alu (
  input  kpec_pkg::alu_ctl_t                  ctl,
  input  logic [kpec_pkg::COUNT_W-1:0]        count_in,
  input  logic [kpec_pkg::LIMIT_W-1:0]        limit,
  output logic [kpec_pkg::COUNT_W-1:0]        count_out,
  output logic                                grant
);

  logic [kpec_pkg::COUNT_W:0] inc;
  logic [kpec_pkg::COUNT_W:0] lim2;
  logic                       nz;

  assign inc  = {1'b0, count_in} + {{kpec_pkg::COUNT_W{1'b0}}, 1'b1};
  assign lim2 = {1'b0, limit, 1'b0};
  assign nz   = (count_in != '0);

  always_comb begin
    count_out = count_in;
    grant     = 1'b0;
    unique case (ctl.op)
      kpec_pkg::ACT_SAMPLE: begin
        if (ctl.fall) begin
          if (inc > lim2) begin
            count_out = {1'b0, limit};
          end else begin
            count_out = inc[kpec_pkg::COUNT_W-1:0];
          end
        end
      end
      kpec_pkg::ACT_TAKE_PRESS,
      kpec_pkg::ACT_TAKE_RELEASE: begin
        grant = nz && ((ctl.op == kpec_pkg::ACT_TAKE_PRESS) || ctl.up);
        if (grant) begin
          count_out = count_in - {{(kpec_pkg::COUNT_W-1){1'b0}}, 1'b1};
        end
      end
      kpec_pkg::ACT_CLEAR: begin
        count_out = '0;
      end
      default: begin
        count_out = count_in;
      end
    endcase
  end

endmodule

### rtl/key_press_event_counter_unit.sv
// Key press event counter.
// Input channel in_valid/in_ready/in_data carries one item: action (sample,
// take press, take release, clear), key line levels and a key index.
// Result channel out_valid/out_ready/out_data returns one item per input:
// granted flag, stored key levels and the addressed key's pending count.
// Configuration channel cfg_valid/cfg_ready/cfg_data writes count_limit;
// it is always ready; the user must write it only while the block is idle,
// and the block itself does not enforce this. One shared count unit visits
// the per-key counters one key per cycle. An item is accepted in idle; the
// scan then visits every key for sample and clear and only the addressed key
// for a take item, and the done state registers the result. A take item whose
// key index is at or above NUM_KEYS skips the scan. in_ready is high only
// while the sequencer is idle; it returns when the result is registered.
// The finished result sits in the output register; a new item may be accepted
// while it waits, and the next result is held until out_ready takes the old.
// Reset clears all counters, sets the stored levels to all keys up and
// count_limit to 10.
module key_press_event_counter_unit #(
  parameter int unsigned NUM_KEYS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  kpec_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output kpec_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kpec_pkg::LIMIT_W-1:0]        cfg_data
);

  localparam int unsigned KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int unsigned CW = (KW > kpec_pkg::INDEX_W) ? KW : kpec_pkg::INDEX_W;
  localparam logic [KW-1:0] LAST_KEY = KW'(NUM_KEYS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t                               state_r;
  kpec_pkg::action_t                    op_r;
  logic [kpec_pkg::LINE_W-1:0]          levels_r;
  logic [kpec_pkg::LINE_W-1:0]          falls_r;
  logic [kpec_pkg::INDEX_W-1:0]         idx_r;
  logic [KW-1:0]                        k_r;
  logic [KW-1:0]                        k_end_r;
  logic [kpec_pkg::COUNT_W-1:0]         pend_r;
  logic                                 grant_r;
  logic [kpec_pkg::LIMIT_W-1:0]         limit_r;
  logic [kpec_pkg::COUNT_W-1:0]         counts_r [NUM_KEYS];
  logic                                 out_valid_r;
  kpec_pkg::out_item_t                  out_r;

  logic [NUM_KEYS-1:0]                  fall_vec;
  logic                                 idx_ok;
  kpec_pkg::alu_ctl_t                   alu_ctl;
  logic [kpec_pkg::COUNT_W-1:0]         alu_out;
  logic                                 alu_grant;
  logic                                 take;
  logic                                 any_nz;

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_fall
    if (i < kpec_pkg::LINE_W) begin : g_line
      assign fall_vec[i] = falls_r[i];
    end else begin : g_noline
      assign fall_vec[i] = 1'b0;
    end
  end

  assign idx_ok  = (32'(in_data.key_index) < NUM_KEYS);
  assign take    = (in_data.action == kpec_pkg::ACT_TAKE_PRESS) ||
                   (in_data.action == kpec_pkg::ACT_TAKE_RELEASE);

  assign alu_ctl.op   = op_r;
  assign alu_ctl.fall = fall_vec[k_r];
  assign alu_ctl.up   = levels_r[idx_r];

  kpec_count_alu u_alu (
    .ctl       (alu_ctl),
    .count_in  (counts_r[k_r]),
    .limit     (limit_r),
    .count_out (alu_out),
    .grant     (alu_grant)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    any_nz = 1'b0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      any_nz = any_nz | (counts_r[i] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      limit_r     <= kpec_pkg::LIMIT_RESET;
      levels_r    <= kpec_pkg::LEVELS_RESET;
      for (int i = 0; i < NUM_KEYS; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      if (out_valid_r && out_ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            op_r    <= in_data.action;
            idx_r   <= in_data.key_index;
            falls_r <= levels_r & ~in_data.key_levels;
            pend_r  <= '0;
            grant_r <= 1'b0;
            if (in_data.action == kpec_pkg::ACT_SAMPLE) begin
              levels_r <= in_data.key_levels;
            end
            if (take) begin
              k_r     <= KW'(in_data.key_index);
              k_end_r <= KW'(in_data.key_index);
              state_r <= idx_ok ? ST_SCAN : ST_DONE;
            end else begin
              k_r     <= '0;
              k_end_r <= LAST_KEY;
              state_r <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          counts_r[k_r] <= alu_out;
          if (CW'(k_r) == CW'(idx_r)) begin
            pend_r  <= alu_out;
            grant_r <= alu_grant;
          end
          if (k_r == k_end_r) begin
            state_r <= ST_DONE;
          end else begin
            k_r <= k_r + KW'(1);
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r         <= 1'b1;
            out_r.granted       <= grant_r;
            out_r.levels_now    <= levels_r;
            out_r.pending_count <= pend_r;
            state_r             <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_grant_only_take: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && out_r.granted |->
      (op_r == kpec_pkg::ACT_TAKE_PRESS || op_r == kpec_pkg::ACT_TAKE_RELEASE))
    else $error("granted set on a non-take item");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && op_r == kpec_pkg::ACT_CLEAR |-> !any_nz)
    else $error("counter nonzero after clear pass");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> (32'(k_r) < NUM_KEYS && k_r <= k_end_r))
    else $error("scan index out of range");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && out_valid_r && !out_ready |=> state_r == ST_DONE)
    else $error("result lost while receiver stalls");
`endif

endmodule
